// ===== hdl/riscv_page_table_walker_macros.svh =====
// Assertion macros shared by the page table walker RTL.
`ifndef RISCV_PAGE_TABLE_WALKER_MACROS_SVH
`define RISCV_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RPTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rptw_pkg.sv =====
// Types and constants shared by the page table walker modules.
`default_nettype none

package rptw_pkg;

	localparam int LEVEL_INDEX_BITS = 9;
	localparam int VA_BITS          = 57;
	localparam int PA_BITS          = 56;
	localparam int PTE_BITS         = 54;
	localparam int PFN_SHIFT        = 10;

	localparam logic [63:0] RAM_BASE_RESET = 64'h0000_0000_8020_0000;

	localparam logic [1:0] MODE_SV48 = 2'd1;
	localparam logic [1:0] MODE_SV57 = 2'd2;

	localparam logic [2:0] LEVEL_LAST = 3'd0;
	localparam logic [2:0] LEVEL_SV39 = 3'd2;
	localparam logic [2:0] LEVEL_SV48 = 3'd3;
	localparam logic [2:0] LEVEL_SV57 = 3'd4;

	typedef enum logic {
		OP_TRANSLATE,
		OP_RESPONSE
	} op_t;

	typedef enum logic {
		KIND_READ_REQ,
		KIND_DONE
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_READ_FAIL,
		ST_NOT_PRESENT,
		ST_PROTOCOL
	} status_t;

	typedef enum logic [2:0] {
		REG_PAGING_MODE,
		REG_LINEAR_MAP_BASE,
		REG_MODULES_START,
		REG_MODULES_LAST,
		REG_KERNEL_IMAGE_BASE,
		REG_KERNEL_PHYS_OFFSET,
		REG_RAM_PHYS_BASE,
		REG_ROOT_TABLE_VADDR
	} reg_idx_t;

	typedef struct packed {
		logic                busy;
		logic [2:0]          level;
		logic [VA_BITS-1:0]  vaddr;
		logic [PA_BITS-1:0]  table_base;
	} walk_state_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] virt_addr;
		logic [63:0] read_data;
		logic        read_ok;
	} item_t;

	typedef struct packed {
		kind_t               kind;
		logic [PA_BITS-1:0]  read_address;
		logic [63:0]         phys_addr;
		status_t             status;
	} result_t;

	// Translation settings as seen by the datapath; delta and root_pa are precomputed.
	typedef struct packed {
		logic [1:0]          paging_mode;
		logic [63:0]         linear_map_base;
		logic [63:0]         modules_start;
		logic [63:0]         modules_last;
		logic [63:0]         kernel_image_base;
		logic [63:0]         kernel_phys_offset;
		logic [63:0]         linear_delta;
		logic [PA_BITS-1:0]  root_pa;
	} xlate_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/riscv_page_table_walker.sv =====
// Top level of the page table walker: stream ports, register file, pipeline.
// A transaction is registered in s1, and its result in the output register that drives m_*.
// Throughput: one transaction per cycle unless a low m_tready holds the output; the walk step logic
// between the s1 and output registers is the only work per transaction.
// The output register holds its result until taken while s1 still accepts one more.
// Reset clears walk state and registers (ram_phys_base to 0x80200000), no result pending.
`default_nettype none
`include "riscv_page_table_walker_macros.svh"

module riscv_page_table_walker #(
	parameter int PAGE_BITS = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata,   // virt_addr[63:0], read_data[127:64], read_ok[128]
	input  wire logic         s_tuser,   // operation
	// master stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // read_address[55:0], phys_addr[119:56], status[121:120]
	output logic              m_tuser,   // result_kind
	// configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	logic [1:0]  paging_mode_q;
	logic [63:0] linear_map_base_q;
	logic [63:0] modules_start_q;
	logic [63:0] modules_last_q;
	logic [63:0] kernel_image_base_q;
	logic [63:0] kernel_phys_offset_q;
	logic [63:0] ram_phys_base_q;
	logic [63:0] root_table_vaddr_q;
	logic [63:0] linear_delta_q;
	logic [rptw_pkg::PA_BITS-1:0] root_pa_q;

	logic                  valid_s1;
	rptw_pkg::item_t       item_s1;
	rptw_pkg::result_t     res_q;
	logic                  m_valid_q;
	rptw_pkg::walk_state_t state_q;
	rptw_pkg::walk_state_t state_nxt;
	rptw_pkg::result_t     res_nxt;
	rptw_pkg::xlate_cfg_t  cfg;
	rptw_pkg::reg_idx_t    reg_idx;
	logic                  cfg_wr;
	logic                  advance;
	logic [63:0]           root_linear;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = rptw_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_mode_q        <= '0;
			linear_map_base_q    <= '0;
			modules_start_q      <= '0;
			modules_last_q       <= '0;
			kernel_image_base_q  <= '0;
			kernel_phys_offset_q <= '0;
			ram_phys_base_q      <= rptw_pkg::RAM_BASE_RESET;
			root_table_vaddr_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				rptw_pkg::REG_PAGING_MODE:        paging_mode_q        <= pwdata[1:0];
				rptw_pkg::REG_LINEAR_MAP_BASE:    linear_map_base_q    <= pwdata;
				rptw_pkg::REG_MODULES_START:      modules_start_q      <= pwdata;
				rptw_pkg::REG_MODULES_LAST:       modules_last_q       <= pwdata;
				rptw_pkg::REG_KERNEL_IMAGE_BASE:  kernel_image_base_q  <= pwdata;
				rptw_pkg::REG_KERNEL_PHYS_OFFSET: kernel_phys_offset_q <= pwdata;
				rptw_pkg::REG_RAM_PHYS_BASE:      ram_phys_base_q      <= pwdata;
				rptw_pkg::REG_ROOT_TABLE_VADDR:   root_table_vaddr_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rptw_pkg::REG_PAGING_MODE:        prdata = 64'(paging_mode_q);
			rptw_pkg::REG_LINEAR_MAP_BASE:    prdata = linear_map_base_q;
			rptw_pkg::REG_MODULES_START:      prdata = modules_start_q;
			rptw_pkg::REG_MODULES_LAST:       prdata = modules_last_q;
			rptw_pkg::REG_KERNEL_IMAGE_BASE:  prdata = kernel_image_base_q;
			rptw_pkg::REG_KERNEL_PHYS_OFFSET: prdata = kernel_phys_offset_q;
			rptw_pkg::REG_RAM_PHYS_BASE:      prdata = ram_phys_base_q;
			rptw_pkg::REG_ROOT_TABLE_VADDR:   prdata = root_table_vaddr_q;
			default:                          prdata = '0;
		endcase
	end

	// Derived settings (linear_delta, root_pa) are registered from the configuration registers.
	assign root_linear = (root_table_vaddr_q >= kernel_image_base_q) ?
		root_table_vaddr_q - kernel_phys_offset_q :
		root_table_vaddr_q - linear_map_base_q + ram_phys_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_delta_q <= rptw_pkg::RAM_BASE_RESET;
			root_pa_q      <= '0;
		end else begin
			linear_delta_q <= ram_phys_base_q - linear_map_base_q;
			root_pa_q      <= root_linear[rptw_pkg::PA_BITS-1:0];
		end
	end

	assign cfg.paging_mode        = paging_mode_q;
	assign cfg.linear_map_base    = linear_map_base_q;
	assign cfg.modules_start      = modules_start_q;
	assign cfg.modules_last       = modules_last_q;
	assign cfg.kernel_image_base  = kernel_image_base_q;
	assign cfg.kernel_phys_offset = kernel_phys_offset_q;
	assign cfg.linear_delta       = linear_delta_q;
	assign cfg.root_pa            = root_pa_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op        <= rptw_pkg::op_t'(s_tuser);
			item_s1.virt_addr <= s_tdata[63:0];
			item_s1.read_data <= s_tdata[127:64];
			item_s1.read_ok   <= s_tdata[128];
		end
	end

	rptw_step #(
		.PAGE_BITS(PAGE_BITS)
	) u_step (
		.item      (item_s1),
		.state     (state_q),
		.cfg       (cfg),
		.res       (res_nxt),
		.state_nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q   <= state_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {6'b000000, res_q.status, res_q.phys_addr, res_q.read_address};

	`RPTW_ASSERT_NOW(a_level_range, state_q.busy, state_q.level <= rptw_pkg::LEVEL_SV57, "walk level out of range")
	`RPTW_ASSERT_NOW(a_req_clean, m_tvalid && (m_tuser == rptw_pkg::KIND_READ_REQ), (m_tdata[121:56] == '0), "read request carries status or address")
	`RPTW_ASSERT_NEXT(a_req_busy, advance && (res_nxt.kind == rptw_pkg::KIND_READ_REQ), state_q.busy, "read request issued without an active walk")
	`RPTW_ASSERT_NEXT(a_done_idle, advance && (res_nxt.kind == rptw_pkg::KIND_DONE) && (res_nxt.status != rptw_pkg::ST_PROTOCOL), !state_q.busy, "walk still active after a finished translation")
	`RPTW_ASSERT_NEXT(a_protocol_hold, advance && (res_nxt.status == rptw_pkg::ST_PROTOCOL), $stable(state_q), "protocol error changed walk state")

endmodule

`default_nettype wire

// ===== hdl/rptw_step.sv =====
// Per-transaction translation and walk step logic.
`default_nettype none

module rptw_step #(
	parameter int PAGE_BITS = 12
) (
	input  var rptw_pkg::item_t      item,
	input  var rptw_pkg::walk_state_t state,
	input  var rptw_pkg::xlate_cfg_t  cfg,
	output rptw_pkg::result_t        res,
	output rptw_pkg::walk_state_t    state_nxt
);

	function automatic int level_shift(input logic [2:0] lvl);
		return PAGE_BITS + rptw_pkg::LEVEL_INDEX_BITS * int'(lvl);
	endfunction

	function automatic logic [rptw_pkg::PA_BITS-1:0] entry_addr(
		input logic [rptw_pkg::PA_BITS-1:0] tb,
		input logic [rptw_pkg::VA_BITS-1:0] va,
		input logic [2:0]                   lvl
	);
		int                                     sh;
		logic [63:0]                            va_ext;
		logic [63:0]                            shifted;
		logic [rptw_pkg::LEVEL_INDEX_BITS-1:0]  idx;
		sh      = level_shift(lvl);
		va_ext  = 64'(va);
		shifted = va_ext >> sh;
		idx     = (sh < 64) ? shifted[rptw_pkg::LEVEL_INDEX_BITS-1:0] : '0;
		return tb + rptw_pkg::PA_BITS'({idx, 3'b000});
	endfunction

	function automatic logic [63:0] low_mask(input logic [2:0] lvl);
		int sh;
		sh = level_shift(lvl);
		return (sh < 64) ? ((64'd1 << sh) - 64'd1) : '1;
	endfunction

	logic [rptw_pkg::PTE_BITS-1:0] pte;
	logic [63:0]                   page;
	logic [63:0]                   leaf_mask;
	logic [63:0]                   linear_pa;
	logic                          linear_hit;
	logic                          in_modules;
	logic [2:0]                    start_level;
	logic [2:0]                    down_level;

	assign pte       = item.read_data[rptw_pkg::PTE_BITS-1:0];
	assign page      = 64'(pte[rptw_pkg::PTE_BITS-1:rptw_pkg::PFN_SHIFT]) << PAGE_BITS;
	assign leaf_mask = low_mask(state.level);
	assign down_level = state.level - 3'd1;

	assign in_modules = (item.virt_addr >= cfg.modules_start) &&
		(item.virt_addr <= cfg.modules_last);
	assign linear_hit = (item.virt_addr >= cfg.linear_map_base) && !in_modules;
	assign linear_pa  = (item.virt_addr >= cfg.kernel_image_base) ?
		item.virt_addr - cfg.kernel_phys_offset : item.virt_addr + cfg.linear_delta;

	always_comb begin
		case (cfg.paging_mode)
			rptw_pkg::MODE_SV48: start_level = rptw_pkg::LEVEL_SV48;
			rptw_pkg::MODE_SV57: start_level = rptw_pkg::LEVEL_SV57;
			default:             start_level = rptw_pkg::LEVEL_SV39;
		endcase
	end

	always_comb begin
		res.kind         = rptw_pkg::KIND_DONE;
		res.read_address = '0;
		res.phys_addr    = '0;
		res.status       = rptw_pkg::ST_OK;
		state_nxt        = state;
		case (item.op)
			rptw_pkg::OP_TRANSLATE: begin
				if (state.busy) begin
					res.status = rptw_pkg::ST_PROTOCOL;
				end else if (linear_hit) begin
					res.phys_addr = linear_pa;
				end else begin
					state_nxt.busy       = 1'b1;
					state_nxt.level      = start_level;
					state_nxt.vaddr      = item.virt_addr[rptw_pkg::VA_BITS-1:0];
					state_nxt.table_base = cfg.root_pa;
					res.kind             = rptw_pkg::KIND_READ_REQ;
					res.read_address     = entry_addr(cfg.root_pa,
						item.virt_addr[rptw_pkg::VA_BITS-1:0], start_level);
				end
			end
			rptw_pkg::OP_RESPONSE: begin
				if (!state.busy) begin
					res.status = rptw_pkg::ST_PROTOCOL;
				end else if (!item.read_ok) begin
					state_nxt.busy = 1'b0;
					res.status     = rptw_pkg::ST_READ_FAIL;
				end else if (!pte[0]) begin
					state_nxt.busy = 1'b0;
					res.status     = rptw_pkg::ST_NOT_PRESENT;
				end else if ((pte[3:1] != 3'b000) || (state.level == rptw_pkg::LEVEL_LAST)) begin
					// leaf: superpages keep the virtual offset below their level
					state_nxt.busy = 1'b0;
					res.phys_addr  = (page & ~leaf_mask) | (64'(state.vaddr) & leaf_mask);
				end else begin
					state_nxt.level      = down_level;
					state_nxt.table_base = page[rptw_pkg::PA_BITS-1:0];
					res.kind             = rptw_pkg::KIND_READ_REQ;
					res.read_address     = entry_addr(page[rptw_pkg::PA_BITS-1:0],
						state.vaddr, down_level);
				end
			end
			default: begin
				res.status = rptw_pkg::ST_PROTOCOL;
			end
		endcase
	end

endmodule

`default_nettype wire
